// ===== rtl/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the response matrix folder
// Transaction payload structs, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package rmf_pkg;

  // Q16.16 value of 1.0, used as the ratio when the generator content is zero
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // Every serial unit (divider, multipliers, root) runs one bit or digit per cycle
  localparam int unsigned STEPS = 32;
  localparam int unsigned CNT_W = $clog2(STEPS);

  // Input transaction: one matrix entry and its column data
  typedef struct packed {
    logic        [31:0] matrix_entry;
    logic        [31:0] gen_content;
    logic signed [31:0] unfolded_value;
    logic        [31:0] unfolded_error;
    logic               row_last;
  } in_t;

  // Output transaction: one folded row
  typedef struct packed {
    logic signed [31:0] folded_value;
    logic        [31:0] folded_error;
  } out_t;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_SQLD = 8'b0000_1000,
    ST_SQ   = 8'b0001_0000,
    ST_ACC  = 8'b0010_0000,
    ST_SQRT = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

endpackage

// ===== rtl/response_matrix_folder.sv =====
// ----------------------------------------------------------------------------
// response_matrix_folder: folds an unfolded spectrum through a response matrix
// Bit-serial divider, shift-add multipliers and a two-bit-per-cycle square
// root share one sequencer; saturating Q16.16 row accumulators.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one matrix entry per transaction, row-major, with
//   the column's generator content, unfolded value and unfolded error. The
//   transaction that carries row_last closes the row and produces one output
//   transaction with the folded value and the root of the squared error sum.
//   Both channels use valid/stall; a transaction moves when valid is high and
//   stall is low.
//   Per input transaction the block runs, between acceptance and the next
//   acceptance, a 32-step restoring divider, a 32-step shift-add multiply for
//   value and error, and a 32-step shift-add square; the divider is skipped
//   when the ratio is fixed (zero generator content or saturated ratio).
//   A row_last transaction adds 32 square-root steps of two bits each, then
//   the load into the output register.
//   The output register holds a finished row while the next items are taken;
//   only a second row end stalls in the output state until the receiver takes
//   the first. Reset clears both sums, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module response_matrix_folder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rmf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rmf_pkg::out_t out_data_o
);

  localparam logic [rmf_pkg::CNT_W-1:0] CntLast = rmf_pkg::CNT_W'(rmf_pkg::STEPS - 1);

  // Control state
  rmf_pkg::state_e             state_q;
  logic [rmf_pkg::CNT_W-1:0]   cnt_q;
  logic                        out_valid_q;
  logic signed [63:0]          vsum_q;
  logic [63:0]                 esum_q;

  // Datapath registers
  logic [31:0] g_q;          // divisor
  logic [31:0] rem_q;        // divider remainder
  logic [31:0] dq_q;         // dividend bits in, quotient bits out
  logic [31:0] vmag_q;       // magnitude of the unfolded value
  logic        neg_q;
  logic [31:0] err_q;
  logic        last_q;
  logic [63:0] p1_q;         // value product
  logic [63:0] p2_q;         // error product, then its square
  logic [31:0] ea_q;         // truncated error term
  logic        esat_q;
  logic signed [63:0] term_q;
  logic [31:0] foldv_q;
  logic [63:0] x_q;          // radicand shift register
  logic [31:0] root_q;
  logic [33:0] srem_q;       // root remainder
  rmf_pkg::out_t out_q;

  // Input decode at acceptance
  logic        in_acc;
  logic        ratio_fixed;
  logic [31:0] ratio_fixed_val;
  logic [31:0] vraw;

  assign in_acc          = in_valid_i && !in_stall_o;
  assign ratio_fixed     = (in_data_i.gen_content == 32'd0) ||
                           ({16'd0, in_data_i.matrix_entry[31:16]} >= in_data_i.gen_content);
  assign ratio_fixed_val = (in_data_i.gen_content == 32'd0) ? rmf_pkg::ONE_Q16 : 32'hFFFF_FFFF;
  assign vraw            = in_data_i.unfolded_value;

  // Restoring divider step
  logic [32:0] div_sh;
  logic        div_ge;
  logic [32:0] div_diff;
  logic [31:0] rem_d;
  logic [31:0] dq_d;

  assign div_sh   = {rem_q, dq_q[31]};
  assign div_ge   = div_sh >= {1'b0, g_q};
  assign div_diff = div_sh - {1'b0, g_q};
  assign rem_d    = div_ge ? div_diff[31:0] : div_sh[31:0];
  assign dq_d     = {dq_q[30:0], div_ge};

  // Shift-add multiplier steps
  logic [32:0] m1_sum;
  logic [32:0] m2_sum;
  logic [31:0] m2_a;

  assign m2_a   = state_q == rmf_pkg::ST_SQ ? ea_q : err_q;
  assign m1_sum = {1'b0, p1_q[63:32]} + (p1_q[0] ? {1'b0, vmag_q} : 33'd0);
  assign m2_sum = {1'b0, p2_q[63:32]} + (p2_q[0] ? {1'b0, m2_a} : 33'd0);

  // Value term: floor of the signed product shifted down to Q16.16
  logic [63:0] p1_round;
  logic [47:0] tmag;
  logic [63:0] term_d;

  assign p1_round = p1_q + 64'h0000_FFFF;
  assign tmag     = neg_q ? p1_round[63:16] : p1_q[63:16];
  assign term_d   = neg_q ? (64'd0 - {16'd0, tmag}) : {16'd0, tmag};

  // Saturating accumulators
  logic [64:0] vs_sum;
  logic [63:0] vsum_d;
  logic [63:0] sq_term;
  logic [64:0] es_sum;
  logic [63:0] esum_d;
  logic [31:0] foldv_d;

  assign vs_sum  = {vsum_q[63], vsum_q} + {term_q[63], term_q};
  assign vsum_d  = (vs_sum[64] != vs_sum[63]) ?
                   (vs_sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) :
                   vs_sum[63:0];
  assign sq_term = esat_q ? 64'hFFFF_FFFF_FFFF_FFFF : p2_q;
  assign es_sum  = {1'b0, esum_q} + {1'b0, sq_term};
  assign esum_d  = es_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : es_sum[63:0];
  assign foldv_d = ((&vsum_d[63:31]) || !(|vsum_d[63:31])) ? vsum_d[31:0] :
                   (vsum_d[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // Square root step, two radicand bits per cycle
  logic [35:0] sr_sh;
  logic [35:0] sr_trial;
  logic        sr_ge;
  logic [35:0] sr_diff;

  assign sr_sh    = {srem_q, x_q[63:62]};
  assign sr_trial = {2'b00, root_q, 2'b01};
  assign sr_ge    = sr_sh >= sr_trial;
  assign sr_diff  = sr_sh - sr_trial;

  // Output register load
  logic out_load;

  assign out_load = (state_q == rmf_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  // Sequencer, sums and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmf_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      vsum_q      <= '0;
      esum_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        rmf_pkg::ST_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= ratio_fixed ? rmf_pkg::ST_MUL : rmf_pkg::ST_DIV;
          end
        end
        rmf_pkg::ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) state_q <= rmf_pkg::ST_MUL;
        end
        rmf_pkg::ST_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) state_q <= rmf_pkg::ST_SQLD;
        end
        rmf_pkg::ST_SQLD: begin
          state_q <= rmf_pkg::ST_SQ;
        end
        rmf_pkg::ST_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) state_q <= rmf_pkg::ST_ACC;
        end
        rmf_pkg::ST_ACC: begin
          if (last_q) begin
            vsum_q  <= '0;
            esum_q  <= '0;
            state_q <= rmf_pkg::ST_SQRT;
          end else begin
            vsum_q  <= vsum_d;
            esum_q  <= esum_d;
            state_q <= rmf_pkg::ST_IDLE;
          end
        end
        rmf_pkg::ST_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) state_q <= rmf_pkg::ST_OUT;
        end
        rmf_pkg::ST_OUT: begin
          if (out_load) state_q <= rmf_pkg::ST_IDLE;
        end
        default: begin
          state_q <= rmf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      rmf_pkg::ST_IDLE: begin
        if (in_acc) begin
          g_q    <= in_data_i.gen_content;
          rem_q  <= {16'd0, in_data_i.matrix_entry[31:16]};
          dq_q   <= {in_data_i.matrix_entry[15:0], 16'd0};
          neg_q  <= vraw[31];
          vmag_q <= vraw[31] ? (32'd0 - vraw) : vraw;
          err_q  <= in_data_i.unfolded_error;
          last_q <= in_data_i.row_last;
          p1_q   <= {32'd0, ratio_fixed_val};
          p2_q   <= {32'd0, ratio_fixed_val};
        end
      end
      rmf_pkg::ST_DIV: begin
        rem_q <= rem_d;
        dq_q  <= dq_d;
        if (cnt_q == CntLast) begin
          p1_q <= {32'd0, dq_d};
          p2_q <= {32'd0, dq_d};
        end
      end
      rmf_pkg::ST_MUL: begin
        p1_q <= {m1_sum, p1_q[31:1]};
        p2_q <= {m2_sum, p2_q[31:1]};
      end
      rmf_pkg::ST_SQLD: begin
        esat_q <= |p2_q[63:48];
        ea_q   <= p2_q[47:16];
        p2_q   <= {32'd0, p2_q[47:16]};
        term_q <= term_d;
      end
      rmf_pkg::ST_SQ: begin
        p2_q <= {m2_sum, p2_q[31:1]};
      end
      rmf_pkg::ST_ACC: begin
        foldv_q <= foldv_d;
        x_q     <= esum_d;
        root_q  <= '0;
        srem_q  <= '0;
      end
      rmf_pkg::ST_SQRT: begin
        srem_q <= sr_ge ? sr_diff[33:0] : sr_sh[33:0];
        root_q <= {root_q[30:0], sr_ge};
        x_q    <= {x_q[61:0], 2'b00};
      end
      rmf_pkg::ST_OUT: begin
        if (out_load) begin
          out_q.folded_value <= foldv_q;
          out_q.folded_error <= root_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = state_q != rmf_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block did not go busy after an input transaction");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rmf_pkg::ST_DIV |-> rem_q < g_q)
    else $error("divider remainder not below divisor");

  a_row_clears_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmf_pkg::ST_ACC && last_q) |=> (vsum_q == 64'd0 && esum_q == 64'd0))
    else $error("sums not cleared at row end");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == rmf_pkg::ST_OUT))
    else $error("output valid rose outside the output state");

endmodule

// ===== sim/response_matrix_folder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// response_matrix_folder_test: self-checking bench for the response folder
// Drives matrix entries row by row, predicts each folded row in fixed point,
// and compares every output transaction with the oldest pending row.
// ----------------------------------------------------------------------------
module response_matrix_folder_test;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
  localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

  logic          clk_i;
  logic          rst_ni      = 1'b0;
  logic          in_valid    = 1'b0;
  logic          in_stall_o;
  rmf_pkg::in_t  in_data     = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  rmf_pkg::out_t out_data_o;

  // Predictor state: open row sums
  longint      row_value_sum  = 0;
  logic [63:0] row_err_sq_sum = '0;

  rmf_pkg::out_t folded_rows_q[$];
  int   mismatch_count = 0;
  int   rows_checked   = 0;
  int   quiet_cycles   = 0;
  int   stall_left     = 0;
  bit   idle_en        = 1'b1;

  response_matrix_folder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // matrix entry over generator content, 1.0 for empty content, saturated
  function automatic logic [31:0] ratio_q16(logic [31:0] m, logic [31:0] g);
    logic [63:0] q;
    if (g == '0) return rmf_pkg::ONE_Q16;
    q = {16'b0, m, 16'b0} / {32'b0, g};
    return (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // floor square root, one result bit per pass from the top
  function automatic logic [31:0] root_floor(logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'b0, trial} * {32'b0, trial} <= x) root = trial;
    end
    return root;
  endfunction

  // add one matrix entry to the open row; returns 1 when the row closes
  function automatic bit fold_item(input rmf_pkg::in_t it, output rmf_pkg::out_t row);
    logic [31:0] r;
    longint      prod;
    longint      term;
    longint      clamped;
    logic [63:0] e;
    logic [63:0] sq;
    row = '0;
    r = ratio_q16(it.matrix_entry, it.gen_content);

    // value term, floor to Q16.16, saturating 64-bit sum
    prod = longint'($signed(it.unfolded_value)) * longint'({32'b0, r});
    term = prod >>> 16;
    if (term > 0 && row_value_sum > S64_MAX - term) row_value_sum = S64_MAX;
    else if (term < 0 && row_value_sum < S64_MIN - term) row_value_sum = S64_MIN;
    else row_value_sum = row_value_sum + term;

    // error term truncated, squared, saturating sum
    e = ({32'b0, it.unfolded_error} * {32'b0, r}) >> 16;
    sq = (e > 64'h0000_0000_FFFF_FFFF) ? '1 : e * e;
    if (row_err_sq_sum > ~sq) row_err_sq_sum = '1;
    else row_err_sq_sum = row_err_sq_sum + sq;

    if (!it.row_last) return 1'b0;

    clamped = row_value_sum;
    if (clamped > S32_MAX) clamped = S32_MAX;
    if (clamped < S32_MIN) clamped = S32_MIN;
    row.folded_value = clamped[31:0];
    row.folded_error = root_floor(row_err_sq_sum);
    row_value_sum  = 0;
    row_err_sq_sum = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int sel;
    if (!idle_en) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // word mix: full random for bit coverage, small values up to 2.0, values near 1.0, extremes
  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom();
    if (sel < 7) return $urandom_range(0, 32'h0002_0000);
    if (sel < 9) return $urandom_range(32'h0000_8000, 32'h0001_8000);
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // one input transaction; valid stays high on return
  task automatic send_item(input rmf_pkg::in_t it);
    int            gap;
    rmf_pkg::out_t row;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (fold_item(it, row)) folded_rows_q.push_back(row);
  endtask

  task automatic send_row(int len);
    rmf_pkg::in_t it;
    for (int c = 0; c < len; c++) begin
      it.matrix_entry   = pick_word();
      it.gen_content    = ($urandom_range(0, 7) == 0) ? 32'h0 : pick_word();
      it.unfolded_value = pick_word();
      if ($urandom_range(0, 1)) it.unfolded_value = -it.unfolded_value;
      it.unfolded_error = pick_word();
      it.row_last       = (c == len - 1);
      send_item(it);
    end
  endtask

  // hold the sender off until every pending row has come out
  task automatic wait_rows_drained();
    in_valid <= 1'b0;
    while (folded_rows_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_directed_cases();
    // unit ratio from empty generator content
    send_item(rmf_pkg::in_t'{rmf_pkg::ONE_Q16, 32'h0, 32'sh0001_0000,
                             rmf_pkg::ONE_Q16, 1'b1});
    // all zero
    send_item(rmf_pkg::in_t'{32'h0, 32'h0, 32'sh0, 32'h0, 1'b1});
    // two-entry row, sums carried
    send_item(rmf_pkg::in_t'{32'h0002_0000, rmf_pkg::ONE_Q16, -32'sh0001_8000,
                             32'h0000_8000, 1'b0});
    send_item(rmf_pkg::in_t'{32'h0000_8000, rmf_pkg::ONE_Q16, 32'sh0003_0000,
                             32'h0002_0000, 1'b1});
    // saturated ratio, positive output clamp, error sum saturates
    send_item(rmf_pkg::in_t'{32'hFFFF_FFFF, 32'h1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    // saturated ratio, most negative value, negative clamp
    send_item(rmf_pkg::in_t'{32'hFFFF_FFFF, 32'h1, 32'sh8000_0000, 32'h0000_0001, 1'b1});
    // equal full-scale entries give exactly 1.0
    send_item(rmf_pkg::in_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh0000_0001, 32'h1, 1'b1});
    // zero ratio
    send_item(rmf_pkg::in_t'{32'h0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    send_item(rmf_pkg::in_t'{32'h1, 32'hFFFF_FFFF, 32'sh8000_0000, 32'h0001_0000, 1'b1});
    // negative term rounds toward minus infinity
    send_item(rmf_pkg::in_t'{rmf_pkg::ONE_Q16, 32'h0002_0000, -32'sh1, 32'h1, 1'b1});
    // error squares just below overflow, then the sum saturates
    send_item(rmf_pkg::in_t'{rmf_pkg::ONE_Q16, rmf_pkg::ONE_Q16, 32'sh0,
                             32'hFFFF_FFFF, 1'b0});
    send_item(rmf_pkg::in_t'{rmf_pkg::ONE_Q16, rmf_pkg::ONE_Q16, 32'sh0,
                             32'hFFFF_FFFF, 1'b0});
    send_item(rmf_pkg::in_t'{32'h0, 32'h0, 32'sh0, 32'h0, 1'b1});
    // largest value passes unchanged
    send_item(rmf_pkg::in_t'{32'h1234_5678, 32'h0, 32'sh7FFF_FFFF, 32'h0, 1'b1});
    // positive and negative terms cancel
    send_item(rmf_pkg::in_t'{rmf_pkg::ONE_Q16, rmf_pkg::ONE_Q16, 32'sh0005_0000,
                             32'h0001_0000, 1'b0});
    send_item(rmf_pkg::in_t'{rmf_pkg::ONE_Q16, rmf_pkg::ONE_Q16, -32'sh0005_0000,
                             32'h0001_0000, 1'b0});
    send_item(rmf_pkg::in_t'{32'h0003_0000, 32'h0003_0000, 32'sh0, 32'h0, 1'b1});
  endtask

  // no gaps and no stalls, then a full pause until results are out
  task automatic test_streaming();
    int sent;
    int len;
    sent = 0;
    idle_en = 1'b0;
    while (sent < 150) begin
      len = $urandom_range(1, 6);
      send_row(len);
      sent += len;
    end
    idle_en = 1'b1;
    wait_rows_drained();
  endtask

  task automatic test_random_traffic();
    int sent;
    int len;
    sent = 0;
    while (sent < 850) begin
      len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10);
      send_row(len);
      sent += len;
    end
  endtask

  task automatic test_long_rows();
    send_row(25);
    send_row(25);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_streaming();
    test_random_traffic();
    test_long_rows();

    wait_rows_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("response_matrix_folder: match");
    else $display("response_matrix_folder: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stall and result check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rmf_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (folded_rows_q.size() == 0) begin
        report_mismatch($sformatf("unexpected row: value %h error %h",
                                  out_data_o.folded_value, out_data_o.folded_error));
      end else begin
        want = folded_rows_q.pop_front();
        if (out_data_o.folded_value !== want.folded_value)
          report_mismatch($sformatf("row %0d folded_value got %h want %h", rows_checked,
                                    out_data_o.folded_value, want.folded_value));
        if (out_data_o.folded_error !== want.folded_error)
          report_mismatch($sformatf("row %0d folded_error got %h want %h", rows_checked,
                                    out_data_o.folded_error, want.folded_error));
      end
      rows_checked++;
    end

    // stall bursts of random length
    if (!idle_en) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Watchdog: cycles without any transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("response_matrix_folder: mismatch");
      $finish;
    end
  end

endmodule
